[design/bcr_pkg.sv]
// Shared types and constants for the bucket clock replacement block.
// Holds request/response payload structs and controller/datapath link structs.
// No dependencies.
package bcr_pkg;

  localparam int MAX_BUCKET_POWER_DEF = 10;
  localparam int COUNTER_BITS_DEF     = 8;
  localparam int ITEMS_W              = 16;
  localparam int VICTIM_W             = 10;
  localparam int CFG_W                = 4;

  localparam logic [CFG_W-1:0]   BUCKET_POWER_RST = 4'd10;
  localparam logic [ITEMS_W-1:0] ITEMS_MAX        = {ITEMS_W{1'b1}};

  // Request mode codes
  localparam logic [2:0] MODE_FIND    = 3'd0;
  localparam logic [2:0] MODE_INSERT  = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_REPLACE = 3'd3;
  localparam logic [2:0] MODE_BUMP    = 3'd4;
  localparam logic [2:0] MODE_EVICT   = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] hash_value;
    logic        outcome_ok;
    logic [7:0]  class_id;
  } req_t;

  typedef struct packed {
    logic [ITEMS_W-1:0]  removed_count;
    logic [VICTIM_W-1:0] victim_bucket;
    logic                evicted;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic acc_write;
    logic sw_read;
    logic sw_check;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic op_access;
    logic op_evict;
    logic sweep_hit;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

[design/bcr_datapath.sv]
// Datapath of the bucket clock replacement block: bucket table memory,
// sweep hand, configuration register and response register.
// Depends on bcr_pkg.
module bcr_datapath #(
  parameter int MAX_BUCKET_POWER = bcr_pkg::MAX_BUCKET_POWER_DEF,
  parameter int COUNTER_BITS     = bcr_pkg::COUNTER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bcr_pkg::CFG_W-1:0] cfg_wr_data,
  input  bcr_pkg::req_t             req_data,
  input  bcr_pkg::ctl_cmd_t         cmd,
  output bcr_pkg::dp_status_t       status,
  input  logic                      rsp_stall,
  output logic                      rsp_valid,
  output bcr_pkg::rsp_t             rsp_data
);
  import bcr_pkg::*;

  localparam int HW    = MAX_BUCKET_POWER;
  localparam int CW    = COUNTER_BITS;
  localparam int EW    = CW + ITEMS_W;
  localparam int DEPTH = 1 << MAX_BUCKET_POWER;
  localparam logic [4:0]    MAXP    = 5'(MAX_BUCKET_POWER);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CFG_W-1:0] cfg_power;
  req_t             item;
  logic [HW-1:0]    hand;
  logic [HW-1:0]    clr_addr;
  logic [HW:0]      visits;
  logic [EW-1:0]    rd_data;
  rsp_t             res;
  logic [EW-1:0]    mem [DEPTH];

  logic [4:0]          eff_power;
  logic [HW:0]         span;
  logic [HW-1:0]       mask;
  logic [HW-1:0]       bucket;
  logic [HW-1:0]       hand_next;
  logic [HW:0]         visits_inc;
  logic [CW-1:0]       rd_cnt;
  logic [ITEMS_W-1:0]  rd_items;
  logic [CW-1:0]       cnt_up;
  logic [CW-1:0]       cnt_down;
  logic [CW-1:0]       acc_cnt;
  logic [ITEMS_W-1:0]  acc_items;
  logic                sweep_hit;
  logic [31:0]         hand_wide;
  logic                mem_we;
  logic [HW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [HW-1:0]       rd_addr;

  // Clamp the bucket power into 1..MAX_BUCKET_POWER
  always_comb begin
    if (cfg_power == '0) begin
      eff_power = 5'd1;
    end else if ({1'b0, cfg_power} > MAXP) begin
      eff_power = MAXP;
    end else begin
      eff_power = {1'b0, cfg_power};
    end
  end

  assign span       = (HW + 1)'(1) << eff_power;
  assign mask       = HW'(span - (HW + 1)'(1));
  assign bucket     = item.hash_value[HW-1:0] & mask;
  assign hand_next  = (hand + HW'(1)) & mask;
  assign visits_inc = visits + (HW + 1)'(1);
  assign hand_wide  = 32'(hand);

  assign rd_cnt   = rd_data[EW-1:ITEMS_W];
  assign rd_items = rd_data[ITEMS_W-1:0];
  assign cnt_up   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CW'(1);
  assign cnt_down = (rd_cnt == '0) ? rd_cnt : rd_cnt - CW'(1);
  assign sweep_hit = (rd_cnt == '0) && (rd_items != '0);

  // Access update: raise counter (kept on delete), adjust item count
  always_comb begin
    acc_cnt   = cnt_up;
    acc_items = rd_items;
    case (item.mode)
      MODE_INSERT: begin
        if (item.outcome_ok && rd_items != ITEMS_MAX) begin
          acc_items = rd_items + ITEMS_W'(1);
        end
      end
      MODE_DELETE: begin
        acc_cnt = rd_cnt;
        if (item.outcome_ok && rd_items != '0) begin
          acc_items = rd_items - ITEMS_W'(1);
        end
      end
      default: begin
        acc_items = rd_items;
      end
    endcase
  end

  // Write port select
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.acc_write) begin
      mem_we  = 1'b1;
      wr_addr = bucket;
      wr_data = {acc_cnt, acc_items};
    end else if (cmd.sw_check) begin
      mem_we  = 1'b1;
      wr_addr = hand;
      wr_data = {cnt_down, (sweep_hit ? ITEMS_W'(0) : rd_items)};
    end
  end

  assign rd_addr = cmd.sw_read ? hand_next : bucket;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_power <= BUCKET_POWER_RST;
      hand      <= '0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_power <= cfg_wr_data;
      end
      if (cmd.sw_read) begin
        hand <= hand_next;
      end
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + HW'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item   <= req_data;
      visits <= '0;
      res    <= '0;
    end else if (cmd.sw_check) begin
      visits <= visits_inc;
      if (sweep_hit) begin
        res.removed_count <= rd_items;
        res.victim_bucket <= hand_wide[VICTIM_W-1:0];
        res.evicted       <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      rsp_data <= res;
    end
  end

  assign status.clear_last = (clr_addr == HW'(DEPTH - 1));
  assign status.op_access  = (item.mode inside {MODE_FIND, MODE_INSERT, MODE_DELETE,
                                                MODE_REPLACE, MODE_BUMP});
  assign status.op_evict   = (item.mode == MODE_EVICT) && (item.class_id != '0);
  assign status.sweep_hit  = sweep_hit;
  assign status.sweep_last = (visits_inc == span);
  assign status.out_free   = !rsp_valid || !rsp_stall;

endmodule

[design/bcr_controller.sv]
// Sequencer of the bucket clock replacement block: clearing pass, access
// read-modify-write, eviction sweep and response hand-off.
// Depends on bcr_pkg.
module bcr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  bcr_pkg::dp_status_t status,
  output bcr_pkg::ctl_cmd_t   cmd
);
  import bcr_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_LOOK     = 3'd2;
  localparam logic [2:0] ST_UPDATE   = 3'd3;
  localparam logic [2:0] ST_SW_READ  = 3'd4;
  localparam logic [2:0] ST_SW_CHECK = 3'd5;
  localparam logic [2:0] ST_PUSH     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status.op_access) begin
          state_next = ST_UPDATE;
        end else if (status.op_evict) begin
          state_next = ST_SW_READ;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_UPDATE: begin
        cmd.acc_write = 1'b1;
        state_next    = ST_PUSH;
      end
      ST_SW_READ: begin
        cmd.sw_read = 1'b1;
        state_next  = ST_SW_CHECK;
      end
      ST_SW_CHECK: begin
        cmd.sw_check = 1'b1;
        if (status.sweep_hit || status.sweep_last) begin
          state_next = ST_PUSH;
        end else begin
          state_next = ST_SW_READ;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

endmodule

[design/bucket_clock_replacement.sv]
// Top level of the bucket clock replacement block: CLOCK-style use counters
// and item counts per hash bucket. Instantiates bcr_controller and
// bcr_datapath; depends on bcr_pkg.
//
//  channel | signals                          | moves
//  --------+----------------------------------+---------------------------------
//  req     | req_valid, req_stall, req_data   | one request (mode, hash, flags)
//  rsp     | rsp_valid, rsp_stall, rsp_data   | one response per request
//  cfg     | cfg_wr_en, cfg_wr_data           | bucket_power write, no handshake
//
// Access: an access request (find, insert, delete, replace, bump) passes through the
//   registered read of the table memory, the write-back and the response load.
// Evict: with a nonzero class_id, a sweep visits buckets until a hit or 2^bucket_power
//   visits; each visit is one read and one write of the table memory.
// Reset: a clearing pass writes all 2^MAX_BUCKET_POWER table entries, one a cycle,
//   with req_stall high; configuration writes are taken during the pass.
// Stalls: a finished response waits in the controller until the output register frees.
module bucket_clock_replacement #(
  parameter int MAX_BUCKET_POWER = bcr_pkg::MAX_BUCKET_POWER_DEF,
  parameter int COUNTER_BITS     = bcr_pkg::COUNTER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bcr_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bcr_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bcr_pkg::rsp_t             rsp_data
);
  import bcr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequence the work: clear, read-modify-write, sweep, hand off
  bcr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the table, hand, bucket_power register and response register
  bcr_datapath #(
    .MAX_BUCKET_POWER (MAX_BUCKET_POWER),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_data    (req_data),
    .cmd         (cmd),
    .status      (status),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .rsp_data    (rsp_data)
  );

`ifndef SYNTHESIS
  // The clearing pass must block requests right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request port open during clearing pass");

  // One request at a time: an accepted request closes the port next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one in flight");

  // A response is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("pending response overwritten");

  // A new response appears only after the controller loaded one
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.out_load))
    else $error("response valid without load");
`endif

endmodule
